FILE: src/vcsm_pkg.sv
// Package for the virtual console scrollback multiplexer.
// Holds word types, opcodes, sizing defaults and the clear-screen sequence.
// Depends on nothing; used by virtual_console_scrollback_mux_top.
`default_nettype none

package vcsm_pkg;

   localparam int NUM_CONSOLES_DEF  = 3;
   localparam int HISTORY_DEPTH_DEF = 80 * 30;

   localparam int CHAR_W      = 8;
   localparam int CLEAR_LEN   = 7;
   localparam int CLEAR_IDX_W = $clog2(CLEAR_LEN);

   typedef enum logic [1:0] {
      OP_PUT    = 2'd0,
      OP_SWITCH = 2'd1,
      OP_PULL   = 2'd2
   } op_type;

   typedef struct packed {
      op_type              opcode;
      logic [1:0]          console;
      logic [CHAR_W-1:0]   char_in;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]   uart_char;
      logic                last;
      logic                rejected;
   } rsp_type;

   // Clear screen and home the cursor: ESC [2J ESC [H.
   function automatic logic [CHAR_W-1:0] clear_byte(input logic [CLEAR_IDX_W-1:0] idx);
      logic [CHAR_W-1:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h1b;
         3'd1:    ch = 8'h5b;
         3'd2:    ch = 8'h32;
         3'd3:    ch = 8'h4a;
         3'd4:    ch = 8'h1b;
         3'd5:    ch = 8'h5b;
         3'd6:    ch = 8'h48;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

FILE: src/virtual_console_scrollback_mux_top.sv
// Top level of the virtual console scrollback multiplexer.
// One history RAM shared by all consoles, per-console ring pointers in flops.
// Depends on vcsm_pkg.
//
//   channel   ports                     handshake
//   -------   -----------------------   ------------------------------------
//   request   start, busy, req_data     word taken when start & !busy
//   response  rsp_strobe, rsp_data      word valid for one cycle, no stall
//
// A put's echo (active console only) or rejection word appears the cycle after it.
// A switch sends the seven clear-screen bytes and is busy until the last is sent.
// A pull does the registered history RAM read, then loads the response register.
// Reset clears all pointers and counts at once; the history RAM is not cleared,
// replay only reads entries written before.
// The receiver cannot stall, so every response word is lost if not sampled.
`default_nettype none

module virtual_console_scrollback_mux_top #(
   parameter int NUM_CONSOLES  = vcsm_pkg::NUM_CONSOLES_DEF,
   parameter int HISTORY_DEPTH = vcsm_pkg::HISTORY_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire vcsm_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output vcsm_pkg::rsp_type      rsp_data
);

   localparam int PosW  = $clog2(HISTORY_DEPTH);
   localparam int CntW  = $clog2(HISTORY_DEPTH + 1);
   localparam int ConW  = (NUM_CONSOLES > 1) ? $clog2(NUM_CONSOLES) : 1;
   localparam int Depth = NUM_CONSOLES * HISTORY_DEPTH;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ
   } state_type;

   state_type                            state_ff, state_in;
   logic [vcsm_pkg::CLEAR_IDX_W-1:0]     clr_idx_ff, clr_idx_in;
   logic [PosW-1:0]                      wp_ff [NUM_CONSOLES];
   logic [PosW-1:0]                      wp_in [NUM_CONSOLES];
   logic [CntW-1:0]                      fill_ff [NUM_CONSOLES];
   logic [CntW-1:0]                      fill_in [NUM_CONSOLES];
   logic [ConW-1:0]                      active_ff, active_in;
   logic [PosW-1:0]                      rptr_ff, rptr_in;
   logic [CntW-1:0]                      rrem_ff, rrem_in;
   logic                                 rd_last_ff, rd_last_in;
   vcsm_pkg::rsp_type                    rsp_ff, rsp_in;
   logic                                 rsp_strobe_ff, rsp_strobe_in;

   logic [vcsm_pkg::CHAR_W-1:0]          hist_mem [Depth];
   logic [vcsm_pkg::CHAR_W-1:0]          rd_data_ff;
   logic                                 mem_we, mem_re;
   logic [AddrW-1:0]                     mem_waddr, mem_raddr;

   logic [ConW-1:0]                      con_idx;
   logic                                 con_ok;
   logic                                 pending;
   logic                                 full;

   assign con_idx = ConW'(req_data.console);
   assign con_ok  = 32'(req_data.console) < NUM_CONSOLES;
   assign pending = rrem_ff != '0;
   assign full    = fill_ff[con_idx] == CntW'(HISTORY_DEPTH);

   // Consoles own consecutive slices of the history RAM.
   assign mem_waddr = AddrW'(con_idx) * AddrW'(HISTORY_DEPTH) + AddrW'(wp_ff[con_idx]);
   assign mem_raddr = AddrW'(active_ff) * AddrW'(HISTORY_DEPTH) + AddrW'(rptr_ff);

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      wp_in         = wp_ff;
      fill_in       = fill_ff;
      active_in     = active_ff;
      rptr_in       = rptr_ff;
      rrem_in       = rrem_ff;
      rd_last_in    = rd_last_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.opcode)
                  vcsm_pkg::OP_PUT: begin
                     if (con_ok) begin
                        if (pending) begin
                           rsp_in        = '{uart_char: '0, last: 1'b0, rejected: 1'b1};
                           rsp_strobe_in = 1'b1;
                        end else begin
                           mem_we = 1'b1;
                           wp_in[con_idx] = (wp_ff[con_idx] == PosW'(HISTORY_DEPTH - 1)) ?
                                            '0 : wp_ff[con_idx] + PosW'(1);
                           if (!full) begin
                              fill_in[con_idx] = fill_ff[con_idx] + CntW'(1);
                           end
                           if (active_ff == con_idx) begin
                              rsp_in = '{uart_char: req_data.char_in, last: 1'b0,
                                         rejected: 1'b0};
                              rsp_strobe_in = 1'b1;
                           end
                        end
                     end
                  end
                  vcsm_pkg::OP_SWITCH: begin
                     if (con_ok) begin
                        active_in     = con_idx;
                        rsp_in        = '{uart_char: vcsm_pkg::clear_byte('0), last: 1'b0,
                                          rejected: 1'b0};
                        rsp_strobe_in = 1'b1;
                        clr_idx_in    = vcsm_pkg::CLEAR_IDX_W'(1);
                        state_in      = ST_CLEAR;
                        if (full) begin
                           rptr_in = wp_ff[con_idx];
                           rrem_in = CntW'(HISTORY_DEPTH);
                        end else begin
                           rptr_in = '0;
                           rrem_in = CntW'(wp_ff[con_idx]);
                        end
                     end
                  end
                  vcsm_pkg::OP_PULL: begin
                     if (pending) begin
                        mem_re     = 1'b1;
                        rptr_in    = (rptr_ff == PosW'(HISTORY_DEPTH - 1)) ?
                                     '0 : rptr_ff + PosW'(1);
                        rrem_in    = rrem_ff - CntW'(1);
                        rd_last_in = rrem_ff == CntW'(1);
                        state_in   = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            rsp_in = '{uart_char: vcsm_pkg::clear_byte(clr_idx_ff),
                       last: clr_idx_ff == vcsm_pkg::CLEAR_IDX_W'(vcsm_pkg::CLEAR_LEN - 1),
                       rejected: 1'b0};
            rsp_strobe_in = 1'b1;
            clr_idx_in    = clr_idx_ff + vcsm_pkg::CLEAR_IDX_W'(1);
            if (clr_idx_ff == vcsm_pkg::CLEAR_IDX_W'(vcsm_pkg::CLEAR_LEN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_in        = '{uart_char: rd_data_ff, last: rd_last_ff, rejected: 1'b0};
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         clr_idx_ff    <= '0;
         for (int i = 0; i < NUM_CONSOLES; i++) begin
            wp_ff[i]   <= '0;
            fill_ff[i] <= '0;
         end
         active_ff     <= '0;
         rptr_ff       <= '0;
         rrem_ff       <= '0;
         rd_last_ff    <= 1'b0;
         rsp_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         wp_ff         <= wp_in;
         fill_ff       <= fill_in;
         active_ff     <= active_in;
         rptr_ff       <= rptr_in;
         rrem_ff       <= rrem_in;
         rd_last_ff    <= rd_last_in;
         rsp_ff        <= rsp_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // History RAM: one write port, one registered read port. Puts are refused
   // while a replay is pending, so a write never races a replay read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= req_data.char_in;
      end
      if (mem_re) begin
         rd_data_ff <= hist_mem[mem_raddr];
      end
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire
